// ===== rtl/watermark_set_assoc_tag_cache_core_assert.svh =====
// Assertion macros shared by the cache RTL.
`ifndef WATERMARK_SET_ASSOC_TAG_CACHE_CORE_ASSERT_SVH
`define WATERMARK_SET_ASSOC_TAG_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WSAC_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("wsac assertion failed");

// Next-cycle implication, disabled during reset.
`define WSAC_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("wsac assertion failed");

`endif

// ===== rtl/wsac_pkg.sv =====
// ---------------------------------------------------------------------------
// wsac_pkg
// Shared widths, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package wsac_pkg;

  localparam int KEY_W     = 32;
  localparam int BYTES_W   = 26;
  localparam int AGE_W     = 8;
  localparam int SLOT_W    = 10;
  localparam int SWEPT_W   = 9;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W   = 1 + AGE_W + KEY_W + BYTES_W;

  // key mod SETS is resolved 8 key bits per cycle
  localparam int MOD_BITS  = 8;
  localparam int MOD_STEPS = KEY_W / MOD_BITS;
  localparam int MCNT_W    = $clog2(MOD_STEPS);

  localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_LOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_MAX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd2;

  localparam logic [BYTES_W-1:0] MAX_RST  = 26'd16777216;
  localparam logic [BYTES_W-1:0] HIGH_RST = 26'd4194304;
  localparam logic [BYTES_W-1:0] LOW_RST  = 26'd3145728;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic mod_step;
    logic sw_rd;
    logic sw_ev;
    logic rd;
    logic upd;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic mod_last;
    logic sweep_need;
    logic low_reached;
    logic rnd_full;
    logic over;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/wsac_ram.sv =====
// ---------------------------------------------------------------------------
// wsac_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module wsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/wsac_datapath.sv =====
// ---------------------------------------------------------------------------
// wsac_datapath
// Set row storage, modulo unit, victim selection, totals and result register.
// ---------------------------------------------------------------------------
module wsac_datapath #(
  parameter int SETS = 256,
  parameter int WAYS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wsac_pkg::cmd_t                    cmd,
  output wsac_pkg::stat_t                   st,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [wsac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wsac_pkg::BYTES_W-1:0]      cfg_data,
  input  logic                              action,
  input  logic [wsac_pkg::KEY_W-1:0]        key,
  input  logic [wsac_pkg::BYTES_W-1:0]      byte_size,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic [wsac_pkg::SLOT_W-1:0]       slot,
  output logic                              replaced,
  output logic [wsac_pkg::KEY_W-1:0]        replaced_key,
  output logic [wsac_pkg::SWEPT_W-1:0]      swept_count,
  output logic [wsac_pkg::STAT_W-1:0]       status,
  output logic [wsac_pkg::BYTES_W-1:0]      resident_bytes
);

  localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RW    = SW + 1;
  localparam int WW    = $clog2(WAYS);
  localparam int EW    = wsac_pkg::ENTRY_W;
  localparam int ROW_W = WAYS * EW;
  localparam int BW    = wsac_pkg::BYTES_W;
  localparam int AGW   = wsac_pkg::AGE_W;
  localparam int KW    = wsac_pkg::KEY_W;
  // entry layout: {valid, age, key, bytes}
  localparam int V_LSB = AGW + KW + BW;
  localparam int A_LSB = KW + BW;
  localparam int K_LSB = BW;
  localparam logic [RW-1:0] SETS_R = RW'(SETS);
  localparam logic [SW-1:0] LAST_SET = SW'(SETS - 1);

  // configuration
  logic [BW-1:0] max_bytes, high_water, low_water;

  // item and walk state
  logic                          act_q;
  logic [KW-1:0]                 key_q, sh_key;
  logic [BW-1:0]                 size_q;
  logic [SW-1:0]                 rem, rem_next;
  logic [wsac_pkg::MCNT_W-1:0]   mcnt;
  logic [BW-1:0]                 total;
  logic [SW-1:0]                 ptr, ptr_adv, clr_cnt;
  logic [SW:0]                   rnd;
  logic [wsac_pkg::SWEPT_W-1:0]  swept;
  logic [wsac_pkg::STAT_W-1:0]   status_q;
  logic                          hit_q, repl_q;
  logic [wsac_pkg::SLOT_W-1:0]   slot_q;
  logic [KW-1:0]                 rkey_q;

  // RAM port
  logic             ram_we, ram_re;
  logic [SW-1:0]    ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, row_rd;

  // combinational results
  logic [RW-1:0]    mt;
  logic [SW-1:0]    mr;
  logic             hit_c, ev_found, fill_found;
  logic [WW-1:0]    hit_way, ev_way, fill_way;
  logic [AGW-1:0]   ev_best, fill_best, age_w;
  logic [BW-1:0]    ev_bytes, fill_bytes, tot_ev, tot_ins;
  logic             fill_valid;
  logic [KW-1:0]    fill_key;
  logic [ROW_W-1:0] row_look, row_ev, row_ins;
  logic [EW-1:0]    ent;
  logic [BW:0]      need;
  logic [31:0]      hit_slot, fill_slot;

  wsac_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (row_rd)
  );

  // 8 restoring modulo steps per cycle, key MSB first
  always_comb begin
    mr = rem;
    mt = '0;
    for (int i = 0; i < wsac_pkg::MOD_BITS; i++) begin
      mt = {mr, sh_key[KW-1-i]};
      if (mt >= SETS_R) begin
        mt = mt - SETS_R;
      end
      mr = mt[SW-1:0];
    end
    rem_next = mr;
  end

  assign ptr_adv = (ptr == LAST_SET) ? '0 : ptr + SW'(1);

  // set search: lookup hit, sweep victim, fill victim
  always_comb begin
    hit_c      = 1'b0;
    hit_way    = '0;
    ev_found   = 1'b0;
    ev_way     = '0;
    ev_best    = '0;
    ev_bytes   = '0;
    fill_found = 1'b0;
    fill_way   = '0;
    fill_best  = '0;
    fill_valid = 1'b0;
    fill_key   = '0;
    fill_bytes = '0;
    row_look   = row_rd;
    row_ev     = row_rd;
    row_ins    = row_rd;
    ent        = '0;
    age_w      = '0;
    for (int w = 0; w < WAYS; w++) begin
      ent = row_rd[w*EW +: EW];
      if (!hit_c && ent[V_LSB] && ent[A_LSB-1:K_LSB] == key_q) begin
        hit_c   = 1'b1;
        hit_way = WW'(w);
      end
      // oldest valid way, last one wins ties
      if (ent[V_LSB] && ent[V_LSB-1:A_LSB] >= ev_best) begin
        ev_best  = ent[V_LSB-1:A_LSB];
        ev_way   = WW'(w);
        ev_bytes = ent[BW-1:0];
        ev_found = 1'b1;
      end
      // first empty way, else strictly oldest nonzero age, else way 0
      if (!fill_found) begin
        if (!ent[V_LSB]) begin
          fill_found = 1'b1;
          fill_way   = WW'(w);
        end else if (ent[V_LSB-1:A_LSB] > fill_best) begin
          fill_best = ent[V_LSB-1:A_LSB];
          fill_way  = WW'(w);
        end
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      ent   = row_rd[w*EW +: EW];
      age_w = ent[V_LSB-1:A_LSB];
      if (ent[V_LSB]) begin
        if (ent[A_LSB-1:K_LSB] != key_q) begin
          if (age_w != wsac_pkg::AGE_MAX) begin
            age_w = age_w + AGW'(1);
          end
        end else if (age_w != '0) begin
          age_w = age_w - AGW'(1);
        end
      end
      row_look[w*EW + A_LSB +: AGW] = age_w;
      if (ev_found && WW'(w) == ev_way) begin
        row_ev[w*EW + V_LSB] = 1'b0;
      end
      if (WW'(w) == fill_way) begin
        fill_valid = ent[V_LSB];
        fill_key   = ent[A_LSB-1:K_LSB];
        fill_bytes = ent[BW-1:0];
        row_ins[w*EW +: EW] = {1'b1, {AGW{1'b0}}, key_q, size_q};
      end
    end
  end

  assign tot_ev    = ev_found ? total - ev_bytes : total;
  assign tot_ins   = (fill_valid ? total - fill_bytes : total) + size_q;
  assign need      = {1'b0, total} + {1'b0, size_q};
  assign hit_slot  = 32'(rem) * 32'(WAYS) + 32'(hit_way);
  assign fill_slot = 32'(rem) * 32'(WAYS) + 32'(fill_way);

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = rem;
    ram_raddr = rem;
    ram_wdata = row_ins;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end
    if (cmd.sw_rd) begin
      ram_re    = 1'b1;
      ram_raddr = ptr_adv;
    end
    if (cmd.sw_ev) begin
      ram_we    = 1'b1;
      ram_waddr = ptr;
      ram_wdata = row_ev;
    end
    if (cmd.rd) begin
      ram_re = 1'b1;
    end
    if (cmd.upd) begin
      ram_we    = 1'b1;
      ram_wdata = act_q ? row_ins : (hit_c ? row_look : row_rd);
    end
  end

  always_comb begin
    st.clr_done    = (clr_cnt == LAST_SET);
    st.mod_last    = (mcnt == wsac_pkg::MCNT_W'(wsac_pkg::MOD_STEPS - 1));
    st.sweep_need  = act_q && (total >= high_water);
    st.low_reached = (tot_ev <= low_water);
    st.rnd_full    = (rnd == (SW+1)'(SETS));
    st.over        = act_q && (need >= {1'b0, max_bytes});
    st.out_free    = !out_valid || !out_stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes  <= wsac_pkg::MAX_RST;
      high_water <= wsac_pkg::HIGH_RST;
      low_water  <= wsac_pkg::LOW_RST;
      total      <= '0;
      ptr        <= '0;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wsac_pkg::CFG_MAX:  max_bytes  <= cfg_data;
          wsac_pkg::CFG_HIGH: high_water <= cfg_data;
          wsac_pkg::CFG_LOW:  low_water  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + SW'(1);
      end
      if (cmd.sw_rd) begin
        ptr <= ptr_adv;
      end
      if (cmd.sw_ev) begin
        total <= tot_ev;
      end
      if (cmd.upd && act_q) begin
        total <= tot_ins;
      end
      // new result, or hold the one still waiting
      out_valid <= (cmd.done && st.out_free) || (out_valid && out_stall);
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q    <= action;
      key_q    <= key;
      sh_key   <= key;
      size_q   <= byte_size;
      rem      <= '0;
      mcnt     <= '0;
      rnd      <= '0;
      swept    <= '0;
      status_q <= wsac_pkg::ST_OK;
      hit_q    <= 1'b0;
      slot_q   <= '0;
      repl_q   <= 1'b0;
      rkey_q   <= '0;
    end
    if (cmd.mod_step) begin
      rem    <= rem_next;
      sh_key <= sh_key << wsac_pkg::MOD_BITS;
      mcnt   <= mcnt + wsac_pkg::MCNT_W'(1);
    end
    if (cmd.sw_rd) begin
      rnd <= rnd + (SW+1)'(1);
    end
    if (cmd.sw_ev) begin
      if (ev_found) begin
        swept <= swept + wsac_pkg::SWEPT_W'(1);
      end
      if (!st.low_reached && st.rnd_full) begin
        status_q <= wsac_pkg::ST_LOW;
      end
    end
    if (cmd.rd && st.over) begin
      status_q <= wsac_pkg::ST_MAX;
    end
    if (cmd.upd) begin
      if (act_q) begin
        slot_q <= fill_slot[wsac_pkg::SLOT_W-1:0];
        repl_q <= fill_valid;
        rkey_q <= fill_valid ? fill_key : '0;
      end else if (hit_c) begin
        hit_q  <= 1'b1;
        slot_q <= hit_slot[wsac_pkg::SLOT_W-1:0];
      end
    end
    if (cmd.done && st.out_free) begin
      hit            <= hit_q;
      slot           <= slot_q;
      replaced       <= repl_q;
      replaced_key   <= rkey_q;
      swept_count    <= swept;
      status         <= status_q;
      resident_bytes <= total;
    end
  end

`include "watermark_set_assoc_tag_cache_core_assert.svh"

  `WSAC_ASSERT_IMP(a_fill_only_ok, clk, rst, cmd.upd && act_q, status_q == wsac_pkg::ST_OK)
  `WSAC_ASSERT_IMP(a_lookup_no_sweep, clk, rst, cmd.done && !act_q, swept == '0)
  `WSAC_ASSERT_IMP(a_round_counted, clk, rst, cmd.sw_ev, rnd != '0)

endmodule

// ===== rtl/wsac_ctrl.sv =====
// ---------------------------------------------------------------------------
// wsac_ctrl
// Sequencer: clear pass, modulo, sweep rounds, row read/update, result.
// ---------------------------------------------------------------------------
module wsac_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  wsac_pkg::stat_t st,
  output wsac_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_SWRD = 3'd3;
  localparam logic [2:0] S_SWEV = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (st.mod_last) state_next = st.sweep_need ? S_SWRD : S_RD;
      end
      S_SWRD: begin
        cmd.sw_rd  = 1'b1;
        state_next = S_SWEV;
      end
      S_SWEV: begin
        cmd.sw_ev = 1'b1;
        if (st.low_reached) begin
          state_next = S_RD;
        end else if (st.rnd_full) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SWRD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = st.over ? S_DONE : S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.done = 1'b1;
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

`include "watermark_set_assoc_tag_cache_core_assert.svh"

  `WSAC_ASSERT_NXT(a_low_goes_fill, clk, rst, state == S_SWEV && st.low_reached, state == S_RD)
  `WSAC_ASSERT_NXT(a_mod_then_work, clk, rst, state == S_MOD && st.mod_last,
                   state == S_SWRD || state == S_RD)
  `WSAC_ASSERT_IMP(a_clr_blocks, clk, rst, state == S_CLR, in_stall && !cmd.load)

endmodule

// ===== rtl/watermark_set_assoc_tag_cache_core.sv =====
// ---------------------------------------------------------------------------
// watermark_set_assoc_tag_cache_core
// Set-associative tag cache with per-way ages and watermark eviction sweep.
// ---------------------------------------------------------------------------
// Sequence: a lookup runs accept, modulo, row read, update and result;
//   an insert adds its sweep rounds, skips the update when over the
//   maximum, and skips read and update when low water is never reached.
// One item at a time; key mod SETS is resolved in steps of 8 bits each.
// Each sweep round is one row read and one row write-back.
// Reset: sync, active high; a clearing pass writes all SETS rows with
//   input stalled; config writes are accepted throughout.
module watermark_set_assoc_tag_cache_core #(
  parameter int SETS = 256,
  parameter int WAYS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // item in
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [wsac_pkg::KEY_W-1:0]        key,
  input  logic [wsac_pkg::BYTES_W-1:0]      byte_size,
  // result out
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic [wsac_pkg::SLOT_W-1:0]       slot,
  output logic                              replaced,
  output logic [wsac_pkg::KEY_W-1:0]        replaced_key,
  output logic [wsac_pkg::SWEPT_W-1:0]      swept_count,
  output logic [wsac_pkg::STAT_W-1:0]       status,
  output logic [wsac_pkg::BYTES_W-1:0]      resident_bytes,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wsac_pkg::BYTES_W-1:0]      cfg_data
);

  wsac_pkg::cmd_t  cmd;
  wsac_pkg::stat_t st;

  // registers are simple flops: always writable
  assign cfg_ready = 1'b1;

  wsac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // row RAM, modulo unit, victim pick, byte total and result register
  wsac_datapath #(.SETS(SETS), .WAYS(WAYS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .action         (action),
    .key            (key),
    .byte_size      (byte_size),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .slot           (slot),
    .replaced       (replaced),
    .replaced_key   (replaced_key),
    .swept_count    (swept_count),
    .status         (status),
    .resident_bytes (resident_bytes)
  );

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the watermark tag cache: directed table, then
// random lookups and inserts against a behavioral predictor, with register
// changes between phases and random idling on both sides.
// ---------------------------------------------------------------------------
module tb;

  localparam int NSETS = 256;
  localparam int NWAYS = 4;
  localparam int NSLOTS = NSETS * NWAYS;
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic                          hit;
    logic [wsac_pkg::SLOT_W-1:0]   slot;
    logic                          replaced;
    logic [wsac_pkg::KEY_W-1:0]    rkey;
    logic [wsac_pkg::SWEPT_W-1:0]  swept;
    logic [wsac_pkg::STAT_W-1:0]   status;
    logic [wsac_pkg::BYTES_W-1:0]  resident;
  } result_t;

  typedef struct packed {
    logic                         act;
    logic [wsac_pkg::KEY_W-1:0]   k;
    logic [wsac_pkg::BYTES_W-1:0] sz;
    logic                         chk;   // typed-in result below is checked too
    result_t                      res;
  } row_t;

  logic clk, rst;
  logic in_valid, in_stall, action;
  logic [wsac_pkg::KEY_W-1:0] key;
  logic [wsac_pkg::BYTES_W-1:0] byte_size;
  logic out_valid, out_stall;
  logic hit, replaced;
  logic [wsac_pkg::SLOT_W-1:0] slot;
  logic [wsac_pkg::KEY_W-1:0] replaced_key;
  logic [wsac_pkg::SWEPT_W-1:0] swept_count;
  logic [wsac_pkg::STAT_W-1:0] status;
  logic [wsac_pkg::BYTES_W-1:0] resident_bytes;
  logic cfg_valid, cfg_ready;
  logic [wsac_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wsac_pkg::BYTES_W-1:0] cfg_data;

  watermark_set_assoc_tag_cache_core #(.SETS(NSETS), .WAYS(NWAYS)) uut (.*);

  // predictor state
  logic                         p_valid [NSLOTS];
  logic [wsac_pkg::KEY_W-1:0]   p_key   [NSLOTS];
  logic [wsac_pkg::AGE_W-1:0]   p_age   [NSLOTS];
  logic [wsac_pkg::BYTES_W-1:0] p_bytes [NSLOTS];
  logic [wsac_pkg::BYTES_W-1:0] p_total;
  int                           p_ptr;
  logic [wsac_pkg::BYTES_W-1:0] lim_max, lim_high, lim_low;

  result_t pending_results[$];
  result_t typed_results[$];
  logic    typed_flag[$];
  int errors = 0;
  int n_results = 0;
  int n_hits, n_sweeps, n_low, n_over, n_repl, n_items;
  int idle_cycles = 0;
  logic hold_req = 1'b0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // one sweep round: evict the oldest valid way of the next set (last wins)
  function automatic int evict_next();
    int b, pick;
    logic [wsac_pkg::AGE_W-1:0] best;
    logic found;
    p_ptr = (p_ptr + 1) % NSETS;
    b = p_ptr * NWAYS;
    found = 0; best = 0; pick = 0;
    for (int w = 0; w < NWAYS; w++)
      if (p_valid[b+w] && p_age[b+w] >= best) begin
        best = p_age[b+w]; pick = w; found = 1;
      end
    if (!found) return 0;
    p_valid[b+pick] = 0;
    p_total = p_total - p_bytes[b+pick];
    return 1;
  endfunction

  function automatic result_t cache_step(logic act, logic [wsac_pkg::KEY_W-1:0] k,
                                         logic [wsac_pkg::BYTES_W-1:0] sz);
    result_t r;
    int b, take;
    logic reached;
    logic [wsac_pkg::AGE_W-1:0] best;
    r = '0;
    b = (k % NSETS) * NWAYS;
    if (act == ACT_LOOKUP) begin
      for (int w = 0; w < NWAYS; w++)
        if (!r.hit && p_valid[b+w] && p_key[b+w] == k) begin
          r.hit = 1; r.slot = wsac_pkg::SLOT_W'(b + w);
        end
      if (r.hit)
        for (int w = 0; w < NWAYS; w++)
          if (p_valid[b+w]) begin
            if (p_key[b+w] != k) begin
              if (p_age[b+w] != wsac_pkg::AGE_MAX) p_age[b+w]++;
            end else if (p_age[b+w] != 0) p_age[b+w]--;
          end
    end else begin
      if (p_total >= lim_high) begin
        reached = 0;
        for (int i = 0; i < NSETS && !reached; i++) begin
          r.swept = r.swept + wsac_pkg::SWEPT_W'(evict_next());
          if (p_total <= lim_low) reached = 1;
        end
        if (!reached) r.status = wsac_pkg::ST_LOW;
      end
      // 27-bit sum: no wrap in the limit test
      if (r.status == wsac_pkg::ST_OK && ({1'b0, p_total} + sz) >= {1'b0, lim_max})
        r.status = wsac_pkg::ST_MAX;
      if (r.status == wsac_pkg::ST_OK) begin
        take = -1; best = 0;
        for (int w = 0; w < NWAYS; w++)
          if (take < 0 || p_valid[b+take]) begin
            if (!p_valid[b+w]) take = w;
            else if (p_age[b+w] > best) begin best = p_age[b+w]; take = w; end
          end
        if (take < 0) take = 0;
        // recheck: first invalid way wins outright
        for (int w = NWAYS-1; w >= 0; w--) if (!p_valid[b+w]) take = w;
        if (p_valid[b+take]) begin
          r.replaced = 1; r.rkey = p_key[b+take];
          p_total = p_total - p_bytes[b+take];
        end
        p_valid[b+take] = 1; p_key[b+take] = k;
        p_bytes[b+take] = sz; p_age[b+take] = 0;
        p_total = p_total + sz;
        r.slot = wsac_pkg::SLOT_W'(b + take);
      end
    end
    r.resident = p_total;
    return r;
  endfunction

  // push one item through the input handshake and queue its expectation
  task automatic send_item(logic act, logic [wsac_pkg::KEY_W-1:0] k,
                           logic [wsac_pkg::BYTES_W-1:0] sz, logic chk,
                           result_t typed);
    result_t r;
    int gap;
    gap = $urandom_range(0, 14) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; action <= act; key <= k; byte_size <= sz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = cache_step(act, k, sz);
    if (r.swept != 0) n_sweeps++;
    if (r.status == wsac_pkg::ST_LOW) n_low++;
    if (r.status == wsac_pkg::ST_MAX) n_over++;
    if (r.replaced) n_repl++;
    if (r.hit) n_hits++;
    pending_results.push_back(r);
    typed_results.push_back(typed);
    typed_flag.push_back(chk);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (2 * NSETS + 40) @(posedge clk);
  endtask

  task automatic write_reg(logic [wsac_pkg::CFG_IDX_W-1:0] idx,
                           logic [wsac_pkg::BYTES_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == wsac_pkg::CFG_MAX) lim_max = v;
    else if (idx == wsac_pkg::CFG_HIGH) lim_high = v;
    else lim_low = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t got, exp;
    logic tf;
    result_t ty;
    if (!rst && out_valid && !out_stall) begin
      got = '{hit, slot, replaced, replaced_key, swept_count, status, resident_bytes};
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        ty = typed_results.pop_front();
        tf = typed_flag.pop_front();
        if (got !== exp) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp, got);
          errors++;
        end
        if (tf && got !== ty) begin
          $display("%0t: table mismatch expected %p actual %p", $time, ty, got);
          errors++;
        end
      end
    end
  end

  // receiver stall: random per result, plus one long hold-off
  initial begin
    int w;
    bit hold_done;
    hold_done = 0;
    out_stall = 1'b1;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1;
        repeat (400) @(negedge clk);
        hold_done = 1;
      end
      w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      if (w != 0) begin
        out_stall <= 1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 0;
      @(negedge clk);
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [wsac_pkg::KEY_W-1:0] key_in_set(int s);
    return {2'($urandom_range(0, 3)), 22'($urandom()), 8'(s)};
  endfunction

  task automatic random_phase(int count, int nsets, int max_sz);
    logic [wsac_pkg::KEY_W-1:0] k;
    int s;
    for (int i = 0; i < count; i++) begin
      s = $urandom_range(0, nsets - 1);
      k = ($urandom_range(0, 19) == 0) ? $urandom() : key_in_set(s);
      if ($urandom_range(0, 1))
        send_item(ACT_INSERT, k, wsac_pkg::BYTES_W'($urandom_range(0, max_sz)), 0, '0);
      else
        send_item(ACT_LOOKUP, k, wsac_pkg::BYTES_W'($urandom()), 0, '0);
    end
  endtask

  row_t dir_rows[$];

  initial begin
    row_t rw;
    n_hits = 0; n_sweeps = 0; n_low = 0; n_over = 0; n_repl = 0;
    n_items = 0;
    rst = 1; in_valid = 0; action = 0; key = 0; byte_size = 0;
    cfg_valid = 0; cfg_index = wsac_pkg::CFG_MAX; cfg_data = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      p_valid[i] = 0; p_key[i] = 0; p_age[i] = 0; p_bytes[i] = 0;
    end
    p_total = 0; p_ptr = 0;
    lim_max = wsac_pkg::MAX_RST; lim_high = wsac_pkg::HIGH_RST;
    lim_low = wsac_pkg::LOW_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed table; typed results are those obvious from an empty cache
    dir_rows = '{
      '{ACT_LOOKUP, 32'h0000_0000, 26'd0, 1, '0},
      '{ACT_LOOKUP, 32'hFFFF_FFFF, 26'h3FF_FFFF, 1, '0},
      '{ACT_INSERT, 32'hFFFF_FFFF, 26'd100, 1,
        '{0, 10'd1020, 0, 0, 0, wsac_pkg::ST_OK, 26'd100}},
      '{ACT_LOOKUP, 32'hFFFF_FFFF, 26'd0, 1,
        '{1, 10'd1020, 0, 0, 0, wsac_pkg::ST_OK, 26'd100}},
      '{ACT_INSERT, 32'h0000_0000, 26'h3FF_FFFF, 1,
        '{0, 0, 0, 0, 0, wsac_pkg::ST_MAX, 26'd100}},
      '{ACT_INSERT, 32'h0000_0000, 26'd0, 1,
        '{0, 0, 0, 0, 0, wsac_pkg::ST_OK, 26'd100}},
      '{ACT_INSERT, 32'h0000_0100, 26'd5, 0, '0},
      '{ACT_INSERT, 32'h0000_0200, 26'd6, 0, '0},
      '{ACT_INSERT, 32'h0000_0300, 26'd7, 0, '0},
      '{ACT_LOOKUP, 32'h0000_0100, 26'd0, 0, '0},
      '{ACT_LOOKUP, 32'h0000_0100, 26'd0, 0, '0},
      '{ACT_INSERT, 32'h0000_0400, 26'd8, 0, '0},  // full set: age victim
      '{ACT_INSERT, 32'h0000_0500, 26'd9, 0, '0},
      '{ACT_LOOKUP, 32'hAAAA_AA00, 26'd0, 0, '0},
      '{ACT_INSERT, 32'h5555_5555, 26'h2AA_AAAA, 0, '0},
      '{ACT_INSERT, 32'hAAAA_AAAA, 26'h155_5555, 0, '0}, // over max
      '{ACT_INSERT, 32'h1234_5601, 26'd3_000_000, 0, '0},
      '{ACT_INSERT, 32'h1234_5602, 26'd1_500_000, 0, '0},
      '{ACT_INSERT, 32'h1234_5603, 26'd10, 0, '0} // above high water: sweep
    };
    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      send_item(rw.act, rw.k, rw.sz, rw.chk, rw.res);
    end
    drain();

    // dense sets so lookups hit and ways age
    random_phase(250, 16, 300000);
    hold_req = 1;                        // long receiver hold-off
    random_phase(40, 16, 300000);
    drain();

    // tight watermarks: frequent sweeps
    write_reg(wsac_pkg::CFG_HIGH, 26'd2000);
    write_reg(wsac_pkg::CFG_LOW, 26'd1000);
    write_reg(wsac_pkg::CFG_MAX, 26'd1_000_000);
    random_phase(250, 32, 600);
    drain();

    // low water zero: full sweeps, often not reached
    write_reg(wsac_pkg::CFG_LOW, 26'd0);
    write_reg(wsac_pkg::CFG_HIGH, 26'd0);
    write_reg(wsac_pkg::CFG_MAX, 26'h3FF_FFFF);
    random_phase(100, 256, 26'h3FF_FFFF);
    drain();

    // extremes: max zero rejects all, then wide open
    write_reg(wsac_pkg::CFG_MAX, 26'd0);
    random_phase(60, 8, 1000);
    drain();
    write_reg(wsac_pkg::CFG_MAX, 26'h3FF_FFFF);
    write_reg(wsac_pkg::CFG_HIGH, 26'h3FF_FFFF);
    write_reg(wsac_pkg::CFG_LOW, 26'h3FF_FFFF);
    random_phase(200, 64, 26'h3FF_FFFF);
    drain();

    write_reg(wsac_pkg::CFG_MAX, wsac_pkg::MAX_RST);
    write_reg(wsac_pkg::CFG_HIGH, 26'd20000);
    write_reg(wsac_pkg::CFG_LOW, 26'd5000);
    random_phase(250, 64, 2000);
    drain();

    $display("Ran %0d items, %0d results: %0d hits, %0d replacements,",
             n_items, n_results, n_hits, n_repl);
    $display("%0d sweeping inserts, %0d low-water misses, %0d over-max rejects",
             n_sweeps, n_low, n_over);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wsac_pkg.sv
rtl/wsac_ram.sv
rtl/wsac_datapath.sv
rtl/wsac_ctrl.sv
rtl/watermark_set_assoc_tag_cache_core.sv
tb/tb.sv
